[hdl/bdascii_pkg.sv]
`timescale 1ns / 1ps

package bdascii_pkg;

    // Widths of the item fields.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // Action codes.
    localparam logic ACTION_UNSIGNED = 1'b0;
    localparam logic ACTION_SIGNED   = 1'b1;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Shift-add-3 correction: a digit of five or more gets three added before the shift.
    localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DABBLE = 4'b0010,
        ST_SKIP   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    // Status reported by the conversion unit.
    typedef struct packed {
        logic busy;
        logic ovf;
    } dabble_status_t;

endpackage

[hdl/bdascii_in_if.sv]
`timescale 1ns / 1ps

interface bdascii_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [bdascii_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

[hdl/bdascii_out_if.sv]
`timescale 1ns / 1ps

interface bdascii_out_if;
    logic                             valid;
    logic                             ready;
    logic [bdascii_pkg::CHAR_W-1:0]   character;
    logic                             last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

[hdl/bdascii_dabble.sv]
`timescale 1ns / 1ps

// Shift-add-3 converter: one binary bit enters the BCD register per cycle.
module bdascii_dabble #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [bdascii_pkg::VALUE_W-1:0]               magnitude,
    output bdascii_pkg::dabble_status_t                   status,
    output logic [MAX_DIGITS-1:0][bdascii_pkg::DIGIT_W-1:0] digits
);

    localparam int CNT_W = $clog2(bdascii_pkg::VALUE_W);

    logic [bdascii_pkg::VALUE_W-1:0]                bin_reg;
    logic [MAX_DIGITS-1:0][bdascii_pkg::DIGIT_W-1:0] bcd_reg;
    logic [MAX_DIGITS-1:0][bdascii_pkg::DIGIT_W-1:0] bcd_next;
    logic [MAX_DIGITS-1:0][bdascii_pkg::DIGIT_W-1:0] adj;
    logic [CNT_W-1:0]                               cnt_reg;
    logic                                           busy_reg;
    logic                                           ovf_reg;

    // Correct every digit, then shift the whole register up by one bit.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= bdascii_pkg::BCD_ADJ_LIMIT)
                   ? bcd_reg[i] + bdascii_pkg::BCD_ADJ : bcd_reg[i];
        end
        bcd_next[0] = {adj[0][2:0], bin_reg[bdascii_pkg::VALUE_W-1]};
        for (int i = 1; i < MAX_DIGITS; i++)
        begin
            bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    // Control: the step counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(bdascii_pkg::VALUE_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath. A carry out of the top digit means the value needs more digits than fit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= magnitude;
            bcd_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[bdascii_pkg::VALUE_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
            ovf_reg <= ovf_reg | adj[MAX_DIGITS-1][3];
        end
    end

    assign status.busy = busy_reg;
    assign status.ovf  = ovf_reg;
    assign digits      = bcd_reg;

endmodule

[hdl/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps

// Binary to decimal ASCII converter. Each input item holds a 32-bit value and an action
// (unsigned or two's-complement signed); the block returns the decimal text one character
// per output item, most significant digit first, '-' first for a negative signed value,
// no leading zeros, and last set on the final character. One item is in work at a time:
// the block takes it, runs it through the shift-add-3 unit (32 shifts of one bit each),
// skips the leading zeros one digit at a time down to the top digit, then sends one
// character per cycle while the output side takes items without stall; output stalls
// hold it. If the value needs more than MAX_DIGITS digits only the low MAX_DIGITS are sent.
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    bdascii_in_if.sink    number,
    bdascii_out_if.source text
);

    localparam int PTR_W = $clog2(MAX_DIGITS);

    bdascii_pkg::state_t                              state_reg;
    bdascii_pkg::state_t                              state_next;
    bdascii_pkg::dabble_status_t                      status;
    logic [MAX_DIGITS-1:0][bdascii_pkg::DIGIT_W-1:0]  digits;
    logic [PTR_W-1:0]                                 ptr_reg;
    logic [PTR_W-1:0]                                 ptr_next;
    logic                                             sign_reg;
    logic                                             sign_next;
    logic                                             out_valid_reg;
    logic                                             out_valid_next;
    logic [bdascii_pkg::CHAR_W-1:0]                   char_reg;
    logic [bdascii_pkg::CHAR_W-1:0]                   char_next;
    logic                                             last_reg;
    logic                                             last_next;
    logic                                             accept;
    logic                                             negative;
    logic                                             slot_free;
    logic [bdascii_pkg::VALUE_W-1:0]                  magnitude;
    logic [bdascii_pkg::DIGIT_W-1:0]                  cur_digit;

    assign number.ready = (state_reg == bdascii_pkg::ST_IDLE);
    assign accept       = number.valid && number.ready;
    assign negative     = (number.action == bdascii_pkg::ACTION_SIGNED)
                       && number.value[bdascii_pkg::VALUE_W-1];
    assign magnitude    = negative ? ('0 - number.value) : number.value;
    assign slot_free    = !out_valid_reg || text.ready;
    assign cur_digit    = digits[ptr_reg];

    bdascii_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .magnitude (magnitude),
        .status    (status),
        .digits    (digits)
    );

    // Sequencer: convert, skip leading zeros, then send the sign and the digits.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            bdascii_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sign_next  = negative;
                    ptr_next   = PTR_W'(MAX_DIGITS - 1);
                    state_next = bdascii_pkg::ST_DABBLE;
                end
            end
            bdascii_pkg::ST_DABBLE:
            begin
                if (!status.busy)
                begin
                    state_next = bdascii_pkg::ST_SKIP;
                end
            end
            bdascii_pkg::ST_SKIP:
            begin
                if (!status.ovf && (ptr_reg != '0) && (cur_digit == '0))
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
                else
                begin
                    state_next = bdascii_pkg::ST_EMIT;
                end
            end
            bdascii_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        sign_next = 1'b0;
                        char_next = bdascii_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                    end
                    else
                    begin
                        char_next = bdascii_pkg::CHAR_ZERO
                                  + {{(bdascii_pkg::CHAR_W - bdascii_pkg::DIGIT_W){1'b0}},
                                     cur_digit};
                        last_next = (ptr_reg == '0);
                        if (ptr_reg == '0)
                        begin
                            state_next = bdascii_pkg::ST_IDLE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = bdascii_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdascii_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_reg      <= sign_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

endmodule
